/* hw/rtl/bpa_pkg.sv */
// Shared types and constants for the bounded parameter adaptation block.
package bpa_pkg;

	typedef enum logic [1:0] {
		CMD_EVAL   = 2'd0,
		CMD_APPLY  = 2'd1,
		CMD_REINIT = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ACT_NONE      = 3'd0,
		ACT_ROLLBACK  = 3'd1,
		ACT_TIMING_UP = 3'd2,
		ACT_TIMING_DN = 3'd3,
		ACT_DUTY_UP   = 3'd4,
		ACT_DUTY_DN   = 3'd5,
		ACT_RAMP_UP   = 3'd6,
		ACT_RAMP_DN   = 3'd7
	} action_t;

	typedef enum logic [2:0] {
		REG_MIN_CONFIDENCE     = 3'd0,
		REG_MAX_FAILURES       = 3'd1,
		REG_MAX_ROLLBACKS      = 3'd2,
		REG_TIMING_MIN         = 3'd3,
		REG_TIMING_MAX         = 3'd4,
		REG_INITIAL_DUTY_PCT   = 3'd5,
		REG_INITIAL_RAMP_ACCEL = 3'd6,
		REG_UNUSED             = 3'd7
	} reg_index_t;

	// Register reset values
	localparam logic [7:0]  MIN_CONFIDENCE_RST     = 8'd128;
	localparam logic [3:0]  MAX_FAILURES_RST       = 4'd3;
	localparam logic [3:0]  MAX_ROLLBACKS_RST      = 4'd3;
	localparam logic [4:0]  TIMING_MIN_RST         = 5'd0;
	localparam logic [4:0]  TIMING_MAX_RST         = 5'd15;
	localparam logic [6:0]  INITIAL_DUTY_PCT_RST   = 7'd5;
	localparam logic [15:0] INITIAL_RAMP_ACCEL_RST = 16'd5000;

	// Tuning limits, duty in half-percent units
	localparam logic [7:0]  DUTY_MIN_HALF = 8'd4;
	localparam logic [7:0]  DUTY_MAX_HALF = 8'd30;
	localparam logic [15:0] RAMP_STEP     = 16'd500;
	localparam logic [15:0] RAMP_MIN      = 16'd1000;
	localparam logic [15:0] RAMP_MAX      = 16'd20000;

	// Metric thresholds: miss rate as a fraction of 65536
	localparam logic [15:0] MISS_HIGH     = 16'd16384;
	localparam logic [15:0] MISS_LOW_MAX  = 16'd3276;
	localparam logic [7:0]  CONF_HIGH     = 8'd220;
	localparam logic [7:0]  DESYNC_LIMIT  = 8'd2;
	localparam logic [3:0]  COUNT_MAX     = 4'd15;

endpackage

/* hw/rtl/bounded_param_adaptation_top.sv */
// Top level of the bounded parameter adaptation block.
//
// Usage: one item enters on the s_ group (s_tuser carries the command, s_tdata the
// sample metrics and an explicit action) and produces exactly one result item on
// the m_ group: the action chosen, whether it was applied, the lock flag and the
// current timing advance, startup duty and ramp acceleration after the step.
// The accepted item is held in an input register, the decision, counter updates
// and clamping are resolved in one short combinational pass, and the outcome
// lands in the result register at the same edge as the tuning state; from there
// it is shown on the m_ group. One item per cycle is taken while the receiver
// takes results; the state loop is a single register-to-register pass.
// Reset (arst_n low) loads the register defaults, the tuning values from the
// initial duty and ramp defaults with timing at zero, clears the counters and the
// lock. When the receiver stalls, the result register holds, the input register
// holds its item, and s_tready drops only once both are full.
// Configuration writes via cfg_we/cfg_index/cfg_data take effect at once and
// do not reload the tuning values; a reinitialise command (cmd 2) does that.
module bounded_param_adaptation_top (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// Input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // [7:0] confidence, [23:8] zc_miss_rate,
	                              // [31:24] desync_recoveries, [34:32] action_in, rest 0
	input  logic [1:0]  s_tuser,  // [1:0] cmd
	// Result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // [2:0] action_taken, [3] applied, [4] locked,
	                              // [9:5] timing_advance, [17:10] startup_duty_half,
	                              // [33:18] ramp_accel, rest 0
);

	// Configuration registers
	logic [7:0]  min_confidence_q;
	logic [3:0]  max_failures_q;
	logic [3:0]  max_rollbacks_q;
	logic [4:0]  timing_min_q;
	logic [4:0]  timing_max_q;
	logic [6:0]  initial_duty_pct_q;
	logic [15:0] initial_ramp_accel_q;

	// Tuning state
	logic [4:0]  timing_now_q, timing_saved_q;
	logic [7:0]  duty_now_q, duty_saved_q;
	logic [15:0] ramp_now_q, ramp_saved_q;
	logic [3:0]  failure_count_q, rollback_count_q;
	logic        lock_q;

	// Input register
	logic        valid_s1;
	logic [1:0]  cmd_s1;
	logic [7:0]  conf_s1;
	logic [15:0] miss_s1;
	logic [7:0]  desync_s1;
	logic [2:0]  action_in_s1;

	// Result register
	logic        valid_s2;
	logic [2:0]  action_s2;
	logic        applied_s2;
	logic        locked_s2;
	logic [4:0]  timing_s2;
	logic [7:0]  duty_s2;
	logic [15:0] ramp_s2;

	logic advance;
	logic accept;

	// Next-state values from the combinational pass
	logic [4:0]  timing_nx, timing_sav_nx;
	logic [7:0]  duty_nx, duty_sav_nx;
	logic [15:0] ramp_nx, ramp_sav_nx;
	logic [3:0]  fail_nx, roll_nx;
	logic        lock_nx;
	logic [2:0]  act;
	logic        done;

	// The item in s1 moves on when the result register is free or being taken
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, ramp_s2, duty_s2, timing_s2, locked_s2, applied_s2, action_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_confidence_q     <= bpa_pkg::MIN_CONFIDENCE_RST;
			max_failures_q       <= bpa_pkg::MAX_FAILURES_RST;
			max_rollbacks_q      <= bpa_pkg::MAX_ROLLBACKS_RST;
			timing_min_q         <= bpa_pkg::TIMING_MIN_RST;
			timing_max_q         <= bpa_pkg::TIMING_MAX_RST;
			initial_duty_pct_q   <= bpa_pkg::INITIAL_DUTY_PCT_RST;
			initial_ramp_accel_q <= bpa_pkg::INITIAL_RAMP_ACCEL_RST;
		end else if (cfg_we) begin
			unique case (bpa_pkg::reg_index_t'(cfg_index))
				bpa_pkg::REG_MIN_CONFIDENCE:     min_confidence_q     <= cfg_data[7:0];
				bpa_pkg::REG_MAX_FAILURES:       max_failures_q       <= cfg_data[3:0];
				bpa_pkg::REG_MAX_ROLLBACKS:      max_rollbacks_q      <= cfg_data[3:0];
				bpa_pkg::REG_TIMING_MIN:         timing_min_q         <= cfg_data[4:0];
				bpa_pkg::REG_TIMING_MAX:         timing_max_q         <= cfg_data[4:0];
				bpa_pkg::REG_INITIAL_DUTY_PCT:   initial_duty_pct_q   <= cfg_data[6:0];
				bpa_pkg::REG_INITIAL_RAMP_ACCEL: initial_ramp_accel_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register: hold the item until the pass can run on it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1       <= s_tuser;
			conf_s1      <= s_tdata[7:0];
			miss_s1      <= s_tdata[23:8];
			desync_s1    <= s_tdata[31:24];
			action_in_s1 <= s_tdata[34:32];
		end
	end

	// Decision and update pass
	always_comb begin
		logic [5:0]  t_inc;
		logic [4:0]  t_dec;
		logic [8:0]  d_inc;
		logic [7:0]  d_dec;
		logic [16:0] r_inc;
		logic [15:0] r_dec;
		logic [4:0]  t_cl;
		logic [7:0]  d_cl;
		logic [15:0] r_cl;
		logic        run;

		timing_nx     = timing_now_q;
		duty_nx       = duty_now_q;
		ramp_nx       = ramp_now_q;
		timing_sav_nx = timing_saved_q;
		duty_sav_nx   = duty_saved_q;
		ramp_sav_nx   = ramp_saved_q;
		fail_nx       = failure_count_q;
		roll_nx       = rollback_count_q;
		lock_nx       = lock_q;
		act           = bpa_pkg::ACT_NONE;
		done          = 1'b0;
		run           = 1'b0;
		t_cl          = timing_now_q;
		d_cl          = duty_now_q;
		r_cl          = ramp_now_q;

		t_inc = {1'b0, timing_now_q} + 6'd1;
		t_dec = timing_now_q - 5'd1;
		d_inc = {1'b0, duty_now_q} + 9'd1;
		d_dec = duty_now_q - 8'd1;
		r_inc = {1'b0, ramp_now_q} + {1'b0, bpa_pkg::RAMP_STEP};
		r_dec = ramp_now_q - bpa_pkg::RAMP_STEP;

		case (bpa_pkg::cmd_t'(cmd_s1))
			bpa_pkg::CMD_EVAL: begin
				run = 1'b1;
				if (lock_q) begin
					act = bpa_pkg::ACT_NONE;
				end else if (conf_s1 < {1'b0, min_confidence_q[7:1]}) begin
					// Failure: count it, lock when the limit is hit, ask for rollback
					if (failure_count_q < bpa_pkg::COUNT_MAX)
						fail_nx = failure_count_q + 4'd1;
					if (fail_nx >= max_failures_q)
						lock_nx = 1'b1;
					act = bpa_pkg::ACT_ROLLBACK;
				end else if (conf_s1 < min_confidence_q) begin
					act = bpa_pkg::ACT_NONE;
				end else begin
					fail_nx = 4'd0;
					if (miss_s1 > bpa_pkg::MISS_HIGH && timing_now_q > timing_min_q)
						act = bpa_pkg::ACT_TIMING_DN;
					else if (miss_s1 <= bpa_pkg::MISS_LOW_MAX && conf_s1 > bpa_pkg::CONF_HIGH
						&& timing_now_q < timing_max_q)
						act = bpa_pkg::ACT_TIMING_UP;
					else if (desync_s1 > bpa_pkg::DESYNC_LIMIT)
						act = bpa_pkg::ACT_DUTY_UP;
					else
						act = bpa_pkg::ACT_NONE;
				end
			end
			bpa_pkg::CMD_APPLY: begin
				run = 1'b1;
				act = action_in_s1;
			end
			bpa_pkg::CMD_REINIT: begin
				timing_nx     = 5'd0;
				duty_nx       = {initial_duty_pct_q, 1'b0};
				ramp_nx       = initial_ramp_accel_q;
				timing_sav_nx = 5'd0;
				duty_sav_nx   = {initial_duty_pct_q, 1'b0};
				ramp_sav_nx   = initial_ramp_accel_q;
				fail_nx       = 4'd0;
				roll_nx       = 4'd0;
				lock_nx       = 1'b0;
			end
			default: ;
		endcase

		// Candidate clamped values for each step direction
		case (bpa_pkg::action_t'(act))
			bpa_pkg::ACT_TIMING_UP: begin
				if (t_inc < {1'b0, timing_min_q})      t_cl = timing_min_q;
				else if (t_inc > {1'b0, timing_max_q}) t_cl = timing_max_q;
				else                                   t_cl = t_inc[4:0];
			end
			bpa_pkg::ACT_TIMING_DN: begin
				if (timing_now_q == 5'd0)      t_cl = timing_min_q;
				else if (t_dec < timing_min_q) t_cl = timing_min_q;
				else if (t_dec > timing_max_q) t_cl = timing_max_q;
				else                           t_cl = t_dec;
			end
			bpa_pkg::ACT_DUTY_UP: begin
				if (d_inc < {1'b0, bpa_pkg::DUTY_MIN_HALF})      d_cl = bpa_pkg::DUTY_MIN_HALF;
				else if (d_inc > {1'b0, bpa_pkg::DUTY_MAX_HALF}) d_cl = bpa_pkg::DUTY_MAX_HALF;
				else                                             d_cl = d_inc[7:0];
			end
			bpa_pkg::ACT_DUTY_DN: begin
				if (duty_now_q == 8'd0)                  d_cl = bpa_pkg::DUTY_MIN_HALF;
				else if (d_dec < bpa_pkg::DUTY_MIN_HALF) d_cl = bpa_pkg::DUTY_MIN_HALF;
				else if (d_dec > bpa_pkg::DUTY_MAX_HALF) d_cl = bpa_pkg::DUTY_MAX_HALF;
				else                                     d_cl = d_dec;
			end
			bpa_pkg::ACT_RAMP_UP: begin
				if (r_inc < {1'b0, bpa_pkg::RAMP_MIN})      r_cl = bpa_pkg::RAMP_MIN;
				else if (r_inc > {1'b0, bpa_pkg::RAMP_MAX}) r_cl = bpa_pkg::RAMP_MAX;
				else                                        r_cl = r_inc[15:0];
			end
			bpa_pkg::ACT_RAMP_DN: begin
				if (ramp_now_q < bpa_pkg::RAMP_STEP)  r_cl = bpa_pkg::RAMP_MIN;
				else if (r_dec < bpa_pkg::RAMP_MIN)   r_cl = bpa_pkg::RAMP_MIN;
				else if (r_dec > bpa_pkg::RAMP_MAX)   r_cl = bpa_pkg::RAMP_MAX;
				else                                  r_cl = r_dec;
			end
			default: ;
		endcase

		// Apply the chosen action unless locked (lock includes one just raised)
		if (run && !lock_nx && act != bpa_pkg::ACT_NONE) begin
			if (act == bpa_pkg::ACT_ROLLBACK) begin
				if (rollback_count_q >= max_rollbacks_q) begin
					lock_nx = 1'b1;
				end else begin
					timing_nx = timing_saved_q;
					duty_nx   = duty_saved_q;
					ramp_nx   = ramp_saved_q;
					if (rollback_count_q < bpa_pkg::COUNT_MAX)
						roll_nx = rollback_count_q + 4'd1;
					done = 1'b1;
				end
			end else begin
				// Save last-known-good, then step
				timing_sav_nx = timing_now_q;
				duty_sav_nx   = duty_now_q;
				ramp_sav_nx   = ramp_now_q;
				timing_nx     = t_cl;
				duty_nx       = d_cl;
				ramp_nx       = r_cl;
				done          = 1'b1;
			end
		end
	end

	// State update, in step with the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_now_q     <= 5'd0;
			duty_now_q       <= {bpa_pkg::INITIAL_DUTY_PCT_RST, 1'b0};
			ramp_now_q       <= bpa_pkg::INITIAL_RAMP_ACCEL_RST;
			timing_saved_q   <= 5'd0;
			duty_saved_q     <= {bpa_pkg::INITIAL_DUTY_PCT_RST, 1'b0};
			ramp_saved_q     <= bpa_pkg::INITIAL_RAMP_ACCEL_RST;
			failure_count_q  <= 4'd0;
			rollback_count_q <= 4'd0;
			lock_q           <= 1'b0;
		end else if (advance) begin
			timing_now_q     <= timing_nx;
			duty_now_q       <= duty_nx;
			ramp_now_q       <= ramp_nx;
			timing_saved_q   <= timing_sav_nx;
			duty_saved_q     <= duty_sav_nx;
			ramp_saved_q     <= ramp_sav_nx;
			failure_count_q  <= fail_nx;
			rollback_count_q <= roll_nx;
			lock_q           <= lock_nx;
		end
	end

	// Result register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			action_s2  <= act;
			applied_s2 <= done;
			locked_s2  <= lock_nx;
			timing_s2  <= timing_nx;
			duty_s2    <= duty_nx;
			ramp_s2    <= ramp_nx;
		end
	end

endmodule

/* tb/bounded_param_adaptation_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the bounded parameter adaptation block.
module bounded_param_adaptation_top_tb;

	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 135;
	localparam int MAX_GAP     = 18;
	localparam int HOLD_CYCLES = 80;
	localparam int FILL_ITEMS  = 12;

	// One input item as the sender sees it
	typedef struct {
		bpa_pkg::cmd_t    cmd;
		logic [7:0]       conf;
		logic [15:0]      miss;
		logic [7:0]       desync;
		bpa_pkg::action_t act;
	} sample_t;

	// One result item, field by field
	typedef struct packed {
		bpa_pkg::action_t action;
		logic             applied;
		logic             locked;
		logic [4:0]       timing;
		logic [7:0]       duty;
		logic [15:0]      ramp;
	} outcome_t;

	// A directed row: the item, and a typed-in result where one is given
	typedef struct {
		sample_t  smp;
		bit       typed;
		outcome_t want;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;

	bounded_param_adaptation_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// Register copies held by the predictor
	logic [7:0]  min_conf_r;
	logic [3:0]  max_fail_r;
	logic [3:0]  max_roll_r;
	logic [4:0]  tmin_r;
	logic [4:0]  tmax_r;
	logic [6:0]  init_duty_r;
	logic [15:0] init_ramp_r;

	// Tuning state: live values, last-known-good copies, counters and lock
	logic [4:0]  timing_q;
	logic [7:0]  duty_q;
	logic [15:0] ramp_q;
	logic [4:0]  timing_good;
	logic [7:0]  duty_good;
	logic [15:0] ramp_good;
	logic [3:0]  fail_cnt;
	logic [3:0]  roll_cnt;
	logic        locked_q;

	// Results predicted but not yet seen, oldest first
	outcome_t outcomes_due[$];
	dir_row_t dir_rows[$];

	int  errors         = 0;
	int  items_sent     = 0;
	int  results_seen   = 0;
	int  rollbacks_done = 0;
	int  locked_results = 0;
	int  cfg_writes     = 0;
	bit  tx_burst       = 0;
	bit  rx_burst       = 0;
	bit  hold_rx_req    = 0;
	int  fill_left      = 0;

	// 8 ns clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Generous overall limit: far beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("%0t: timeout with %0d results outstanding", $time, outcomes_due.size());
		$display("TEST FAILED");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Load the initial tuning values; no clamping, timing always starts at zero
	function void reload_tuning();
		timing_q    = '0;
		duty_q      = {init_duty_r, 1'b0};
		ramp_q      = init_ramp_r;
		timing_good = timing_q;
		duty_good   = duty_q;
		ramp_good   = ramp_q;
		fail_cnt    = '0;
		roll_cnt    = '0;
		locked_q    = 1'b0;
	endfunction

	function void reset_predictor();
		min_conf_r  = bpa_pkg::MIN_CONFIDENCE_RST;
		max_fail_r  = bpa_pkg::MAX_FAILURES_RST;
		max_roll_r  = bpa_pkg::MAX_ROLLBACKS_RST;
		tmin_r      = bpa_pkg::TIMING_MIN_RST;
		tmax_r      = bpa_pkg::TIMING_MAX_RST;
		init_duty_r = bpa_pkg::INITIAL_DUTY_PCT_RST;
		init_ramp_r = bpa_pkg::INITIAL_RAMP_ACCEL_RST;
		reload_tuning();
	endfunction

	// Pick the action a metrics sample asks for; a failure may lock the block
	function bpa_pkg::action_t choose_action(logic [7:0] conf, logic [15:0] miss,
	                                         logic [7:0] desync);
		if (locked_q)
			return bpa_pkg::ACT_NONE;
		if (conf < (min_conf_r >> 1)) begin
			if (fail_cnt < bpa_pkg::COUNT_MAX)
				fail_cnt = fail_cnt + 4'd1;
			if (fail_cnt >= max_fail_r)
				locked_q = 1'b1;
			return bpa_pkg::ACT_ROLLBACK;
		end
		if (conf < min_conf_r)
			return bpa_pkg::ACT_NONE;
		fail_cnt = '0;
		if (miss > bpa_pkg::MISS_HIGH) begin
			if (timing_q > tmin_r)
				return bpa_pkg::ACT_TIMING_DN;
		end else if (miss <= bpa_pkg::MISS_LOW_MAX && conf > bpa_pkg::CONF_HIGH) begin
			if (timing_q < tmax_r)
				return bpa_pkg::ACT_TIMING_UP;
		end
		if (desync > bpa_pkg::DESYNC_LIMIT)
			return bpa_pkg::ACT_DUTY_UP;
		return bpa_pkg::ACT_NONE;
	endfunction

	// Restore the last-known-good values, or lock once the rollbacks are used up
	function bit restore_saved();
		if (roll_cnt >= max_roll_r) begin
			locked_q = 1'b1;
			return 1'b0;
		end
		timing_q = timing_good;
		duty_q   = duty_good;
		ramp_q   = ramp_good;
		if (roll_cnt < bpa_pkg::COUNT_MAX)
			roll_cnt = roll_cnt + 4'd1;
		return 1'b1;
	endfunction

	function bit apply_tuning(bpa_pkg::action_t a);
		if (locked_q || a == bpa_pkg::ACT_NONE)
			return 1'b0;
		if (a == bpa_pkg::ACT_ROLLBACK)
			return restore_saved();
		timing_good = timing_q;
		duty_good   = duty_q;
		ramp_good   = ramp_q;
		case (a)
			bpa_pkg::ACT_TIMING_UP:
				timing_q = 5'(clamp_to(timing_q + 1, tmin_r, tmax_r));
			bpa_pkg::ACT_TIMING_DN:
				timing_q = 5'((timing_q == 0) ? tmin_r
				              : clamp_to(timing_q - 1, tmin_r, tmax_r));
			bpa_pkg::ACT_DUTY_UP:
				duty_q = 8'(clamp_to(duty_q + 1, bpa_pkg::DUTY_MIN_HALF,
				                     bpa_pkg::DUTY_MAX_HALF));
			bpa_pkg::ACT_DUTY_DN:
				duty_q = 8'((duty_q == 0) ? bpa_pkg::DUTY_MIN_HALF
				            : clamp_to(duty_q - 1, bpa_pkg::DUTY_MIN_HALF,
				                       bpa_pkg::DUTY_MAX_HALF));
			bpa_pkg::ACT_RAMP_UP:
				ramp_q = 16'(clamp_to({16'd0, ramp_q} + bpa_pkg::RAMP_STEP,
				                      bpa_pkg::RAMP_MIN, bpa_pkg::RAMP_MAX));
			default:
				ramp_q = 16'((ramp_q < bpa_pkg::RAMP_STEP) ? bpa_pkg::RAMP_MIN
				             : clamp_to(ramp_q - bpa_pkg::RAMP_STEP,
				                        bpa_pkg::RAMP_MIN, bpa_pkg::RAMP_MAX));
		endcase
		return 1'b1;
	endfunction

	// Advance the tuning state by one item and return the result it gives
	function outcome_t adapt_step(sample_t s);
		outcome_t         o;
		bpa_pkg::action_t a;
		bit               done;
		a    = bpa_pkg::ACT_NONE;
		done = 1'b0;
		case (s.cmd)
			bpa_pkg::CMD_EVAL: begin
				a    = choose_action(s.conf, s.miss, s.desync);
				done = apply_tuning(a);
			end
			bpa_pkg::CMD_APPLY: begin
				a    = s.act;
				done = apply_tuning(a);
			end
			bpa_pkg::CMD_REINIT: reload_tuning();
			default: ;
		endcase
		o.action  = a;
		o.applied = done;
		o.locked  = locked_q;
		o.timing  = timing_q;
		o.duty    = duty_q;
		o.ramp    = ramp_q;
		return o;
	endfunction

	// ---------------------------------------------------------------- stimulus

	function automatic dir_row_t row_pred(bpa_pkg::cmd_t c, int conf, int miss, int desync,
	                                      bpa_pkg::action_t a);
		dir_row_t r;
		r.smp.cmd    = c;
		r.smp.conf   = conf[7:0];
		r.smp.miss   = miss[15:0];
		r.smp.desync = desync[7:0];
		r.smp.act    = a;
		r.typed      = 1'b0;
		r.want       = '0;
		return r;
	endfunction

	// Row whose result is the untouched reset view under the reset registers
	function automatic dir_row_t row_init_view(bpa_pkg::cmd_t c, int conf, int miss,
	                                           int desync, bpa_pkg::action_t a);
		dir_row_t r;
		r = row_pred(c, conf, miss, desync, a);
		r.typed = 1'b1;
		r.want  = '{action: bpa_pkg::ACT_NONE, applied: 1'b0, locked: 1'b0,
		            timing: 5'd0, duty: 8'd10, ramp: 16'd5000};
		return r;
	endfunction

	// Random item, leaning on the thresholds that steer the decision
	function automatic sample_t random_sample();
		sample_t     s;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45)
			s.cmd = bpa_pkg::CMD_EVAL;
		else if (r < 85)
			s.cmd = bpa_pkg::CMD_APPLY;
		else if (r < 93)
			s.cmd = bpa_pkg::CMD_REINIT;
		else
			s.cmd = bpa_pkg::CMD_NOP;
		case ($urandom_range(0, 3))
			0:       s.conf = 8'($urandom_range(0, 255));
			1:       s.conf = 8'($urandom_range(0, min_conf_r));
			2:       s.conf = 8'($urandom_range(min_conf_r, 255));
			default: s.conf = 8'($urandom_range(bpa_pkg::CONF_HIGH + 1, 255));
		endcase
		case ($urandom_range(0, 3))
			0:       s.miss = 16'($urandom_range(0, 65535));
			1:       s.miss = 16'($urandom_range(0, bpa_pkg::MISS_LOW_MAX));
			2:       s.miss = 16'($urandom_range(bpa_pkg::MISS_HIGH + 1, 65535));
			default: s.miss = 16'($urandom_range(0, 1) ? $urandom_range(3270, 3282)
			                                           : $urandom_range(16378, 16390));
		endcase
		s.desync = 8'($urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(0, 255));
		s.act    = bpa_pkg::action_t'($urandom_range(0, 7));
		return s;
	endfunction

	// Offer one item after a random gap (none in a burst or while filling); call and return at a falling edge
	task automatic send_sample(sample_t s, bit typed, outcome_t want);
		outcome_t    pred;
		int unsigned gap;
		gap = (tx_burst || fill_left > 0) ? 0 : $urandom_range(0, MAX_GAP);
		if (fill_left > 0)
			fill_left--;
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {5'd0, s.act, s.desync, s.miss, s.conf};
		s_tuser  = s.cmd;
		do @(posedge clk); while (!s_tready);
		// Run the predictor on every row so its state follows the block
		pred = adapt_step(s);
		outcomes_due.push_back(typed ? want : pred);
		items_sent++;
		@(negedge clk);
	endtask

	// Drop valid and hold until every result is in, then let the pipe settle
	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (outcomes_due.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Write one register; the predictor copy follows at once as the block is idle
	task automatic write_reg(bpa_pkg::reg_index_t idx, int unsigned val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val[15:0];
		case (idx)
			bpa_pkg::REG_MIN_CONFIDENCE:     min_conf_r  = val[7:0];
			bpa_pkg::REG_MAX_FAILURES:       max_fail_r  = val[3:0];
			bpa_pkg::REG_MAX_ROLLBACKS:      max_roll_r  = val[3:0];
			bpa_pkg::REG_TIMING_MIN:         tmin_r      = val[4:0];
			bpa_pkg::REG_TIMING_MAX:         tmax_r      = val[4:0];
			bpa_pkg::REG_INITIAL_DUTY_PCT:   init_duty_r = val[6:0];
			bpa_pkg::REG_INITIAL_RAMP_ACCEL: init_ramp_r = val[15:0];
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
	endtask

	// Register settings per phase: reset values, both extremes, an inverted
	// timing window, then random settings
	task automatic set_config(int p);
		case (p)
			0: ;
			1: begin
				write_reg(bpa_pkg::REG_MIN_CONFIDENCE, 0);
				write_reg(bpa_pkg::REG_MAX_FAILURES, 1);
				write_reg(bpa_pkg::REG_MAX_ROLLBACKS, 1);
				write_reg(bpa_pkg::REG_TIMING_MIN, 0);
				write_reg(bpa_pkg::REG_TIMING_MAX, 0);
				write_reg(bpa_pkg::REG_INITIAL_DUTY_PCT, 0);
				write_reg(bpa_pkg::REG_INITIAL_RAMP_ACCEL, 0);
			end
			2: begin
				write_reg(bpa_pkg::REG_MIN_CONFIDENCE, 255);
				write_reg(bpa_pkg::REG_MAX_FAILURES, 15);
				write_reg(bpa_pkg::REG_MAX_ROLLBACKS, 15);
				write_reg(bpa_pkg::REG_TIMING_MIN, 30);
				write_reg(bpa_pkg::REG_TIMING_MAX, 30);
				write_reg(bpa_pkg::REG_INITIAL_DUTY_PCT, 100);
				write_reg(bpa_pkg::REG_INITIAL_RAMP_ACCEL, 65535);
				// An unused index must leave every register alone
				write_reg(bpa_pkg::REG_UNUSED, 16'hFFFF);
			end
			3: begin
				write_reg(bpa_pkg::REG_MIN_CONFIDENCE, $urandom_range(60, 200));
				write_reg(bpa_pkg::REG_MAX_FAILURES, $urandom_range(1, 6));
				write_reg(bpa_pkg::REG_MAX_ROLLBACKS, $urandom_range(1, 6));
				write_reg(bpa_pkg::REG_TIMING_MIN, 20);
				write_reg(bpa_pkg::REG_TIMING_MAX, 5);
				write_reg(bpa_pkg::REG_INITIAL_DUTY_PCT, $urandom_range(0, 100));
				write_reg(bpa_pkg::REG_INITIAL_RAMP_ACCEL, $urandom_range(0, 65535));
			end
			default: begin
				write_reg(bpa_pkg::REG_MIN_CONFIDENCE, $urandom_range(0, 255));
				write_reg(bpa_pkg::REG_MAX_FAILURES, $urandom_range(1, 15));
				write_reg(bpa_pkg::REG_MAX_ROLLBACKS, $urandom_range(1, 15));
				write_reg(bpa_pkg::REG_TIMING_MIN, $urandom_range(0, 30));
				write_reg(bpa_pkg::REG_TIMING_MAX, $urandom_range(0, 30));
				write_reg(bpa_pkg::REG_INITIAL_DUTY_PCT, $urandom_range(0, 100));
				write_reg(bpa_pkg::REG_INITIAL_RAMP_ACCEL, $urandom_range(0, 65535));
			end
		endcase
		cfg_we = 1'b0;
	endtask

	// ---------------------------------------------------------------- checking

	function void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// Compare one result item with the oldest prediction
	function void check_result(logic [39:0] d);
		outcome_t want;
		if (outcomes_due.size() == 0) begin
			$display("%0t: result %h arrived with nothing expected, expected none, actual %h",
			         $time, d, d);
			errors++;
			return;
		end
		want = outcomes_due.pop_front();
		check_field("action_taken",      want.action,  d[2:0]);
		check_field("applied",           want.applied, d[3]);
		check_field("locked",            want.locked,  d[4]);
		check_field("timing_advance",    want.timing,  d[9:5]);
		check_field("startup_duty_half", want.duty,    d[17:10]);
		check_field("ramp_accel",        want.ramp,    d[33:18]);
		check_field("tdata padding",     0,            d[39:34]);
		results_seen++;
		if (d[2:0] == bpa_pkg::ACT_ROLLBACK && d[3])
			rollbacks_done++;
		if (d[4])
			locked_results++;
	endfunction

	// Receiver: stall a random number of cycles before each item, or hold off
	// for a long stretch when asked, then take the next result
	initial begin
		int unsigned stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_rx_req) begin
				hold_rx_req = 1'b0;
				m_tready    = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
				if (stall > 0) begin
					m_tready = 1'b0;
					repeat (stall) @(negedge clk);
				end
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
			check_result(m_tdata);
		end
	end

	// ---------------------------------------------------------------- main flow

	initial begin
		sample_t  smp;
		outcome_t no_want;
		no_want   = '0;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = bpa_pkg::REG_MIN_CONFIDENCE;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = bpa_pkg::CMD_NOP;
		reset_predictor();

		// Directed rows, all under the reset register values
		dir_rows.push_back(row_init_view(bpa_pkg::CMD_NOP, 255, 65535, 255,
		                                 bpa_pkg::ACT_RAMP_DN));
		dir_rows.push_back(row_init_view(bpa_pkg::CMD_APPLY, 0, 0, 0, bpa_pkg::ACT_NONE));
		dir_rows.push_back(row_pred(bpa_pkg::CMD_EVAL, 255, 0, 0, bpa_pkg::ACT_NONE));
		dir_rows.push_back(row_pred(bpa_pkg::CMD_EVAL, 255, 65535, 255, bpa_pkg::ACT_NONE));
		dir_rows.push_back(row_pred(bpa_pkg::CMD_EVAL, 128, 16384, 3, bpa_pkg::ACT_NONE));
		dir_rows.push_back(row_pred(bpa_pkg::CMD_EVAL, 127, 0, 0, bpa_pkg::ACT_NONE));
		dir_rows.push_back(row_pred(bpa_pkg::CMD_EVAL, 64, 3276, 2, bpa_pkg::ACT_NONE));
		// Timing down from zero lands on the timing minimum
		dir_rows.push_back(row_pred(bpa_pkg::CMD_APPLY, 0, 0, 0, bpa_pkg::ACT_TIMING_DN));
		dir_rows.push_back(row_pred(bpa_pkg::CMD_APPLY, 0, 0, 0, bpa_pkg::ACT_TIMING_UP));
		dir_rows.push_back(row_pred(bpa_pkg::CMD_APPLY, 0, 0, 0, bpa_pkg::ACT_DUTY_UP));
		dir_rows.push_back(row_pred(bpa_pkg::CMD_APPLY, 0, 0, 0, bpa_pkg::ACT_DUTY_DN));
		dir_rows.push_back(row_pred(bpa_pkg::CMD_APPLY, 0, 0, 0, bpa_pkg::ACT_RAMP_UP));
		dir_rows.push_back(row_pred(bpa_pkg::CMD_APPLY, 0, 0, 0, bpa_pkg::ACT_RAMP_DN));
		dir_rows.push_back(row_pred(bpa_pkg::CMD_APPLY, 0, 0, 0, bpa_pkg::ACT_ROLLBACK));
		// Three failures in a row: the last one locks and its rollback is not applied
		dir_rows.push_back(row_pred(bpa_pkg::CMD_EVAL, 63, 0, 0, bpa_pkg::ACT_NONE));
		dir_rows.push_back(row_pred(bpa_pkg::CMD_EVAL, 0, 0, 0, bpa_pkg::ACT_NONE));
		dir_rows.push_back(row_pred(bpa_pkg::CMD_EVAL, 0, 65535, 255, bpa_pkg::ACT_NONE));
		// While locked nothing moves
		dir_rows.push_back(row_pred(bpa_pkg::CMD_EVAL, 255, 0, 255, bpa_pkg::ACT_NONE));
		dir_rows.push_back(row_pred(bpa_pkg::CMD_APPLY, 0, 0, 0, bpa_pkg::ACT_RAMP_UP));
		dir_rows.push_back(row_init_view(bpa_pkg::CMD_REINIT, 0, 65535, 255,
		                                 bpa_pkg::ACT_RAMP_DN));
		// Rollback limit: the fourth rollback locks and changes nothing
		dir_rows.push_back(row_pred(bpa_pkg::CMD_APPLY, 0, 0, 0, bpa_pkg::ACT_ROLLBACK));
		dir_rows.push_back(row_pred(bpa_pkg::CMD_APPLY, 0, 0, 0, bpa_pkg::ACT_ROLLBACK));
		dir_rows.push_back(row_pred(bpa_pkg::CMD_APPLY, 0, 0, 0, bpa_pkg::ACT_ROLLBACK));
		dir_rows.push_back(row_pred(bpa_pkg::CMD_APPLY, 0, 0, 0, bpa_pkg::ACT_ROLLBACK));
		dir_rows.push_back(row_init_view(bpa_pkg::CMD_REINIT, 255, 0, 0, bpa_pkg::ACT_NONE));

		// Hold reset, then release it away from the rising edge
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[k])
			send_sample(dir_rows[k].smp, dir_rows[k].typed, dir_rows[k].want);

		for (int p = 0; p < PHASES; p++) begin
			// Registers change only with the block drained
			wait_drained();
			set_config(p);
			tx_burst = (p == 2 || p == 6);
			rx_burst = (p == 2 || p == 5);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// Long receiver hold-off while the sender keeps pushing: fill the block
				if (p == 3 && i == 30) begin
					hold_rx_req = 1'b1;
					fill_left   = FILL_ITEMS;
				end
				// Sender pause until every result is back
				if (p == 5 && i == 40)
					wait_drained();
				smp = random_sample();
				send_sample(smp, 1'b0, no_want);
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		$display("Run covered %0d items across %0d register settings (%0d register writes).",
		         items_sent, PHASES, cfg_writes);
		$display("Checked %0d results: %0d rollbacks applied, %0d with the lock set, %0d errors.",
		         results_seen, rollbacks_done, locked_results, errors);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/bpa_pkg.sv
hw/rtl/bounded_param_adaptation_top.sv
tb/bounded_param_adaptation_top_tb.sv
